// ----- design/efb_pkg.sv -----
// ----------------------------------------------------------------------------
// efb_pkg: shared types and constants for the escaped frame builder
// Line constants, the queue entry layout, the back-end phase codes and the
// byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package efb_pkg;

   localparam logic [7:0]  ESC_BYTE       = 8'h7d;
   localparam logic [7:0]  ESC_FLAG_CODE  = 8'h02;
   localparam logic [7:0]  ESC_SELF_CODE  = 8'h01;
   localparam logic [7:0]  FLAG_RESET     = 8'h7e;
   localparam logic [31:0] CRC_POLY       = 32'hedb88320;
   localparam logic [31:0] CRC_INIT       = 32'hffffffff;
   localparam int          QUEUE_DEPTH_DEF = 4;

   // One classified payload byte waiting for the serializer.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        open_frame;  // send the opening flag first
      logic [31:0] crc_out;     // final CRC, valid when last_byte is set
   } efb_entry_type;

   typedef enum logic [1:0] {
      PH_OPEN,
      PH_DATA,
      PH_CRC,
      PH_CLOSE
   } efb_phase_type;

   // Reflected CRC-32, one byte.
   function automatic logic [31:0] crc_update(input logic [31:0] crc_val,
                                              input logic [7:0]  byte_val);
      logic [31:0] c;
      c = crc_val ^ {24'd0, byte_val};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- design/efb_req_if.sv -----
// ----------------------------------------------------------------------------
// efb_req_if: payload byte channel
// Valid/ready channel carrying one payload byte and its last mark.
// ----------------------------------------------------------------------------
interface efb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- design/efb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// efb_rsp_if: line byte channel
// Valid/ready channel carrying one line byte with its end marks.
// ----------------------------------------------------------------------------
interface efb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_end;

   modport source (output valid, output out_byte, output run_last, output frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input frame_end,
                   output ready);
endinterface

// ----- design/efb_csr_if.sv -----
// ----------------------------------------------------------------------------
// efb_csr_if: register write channel
// Valid/ready channel carrying the flag byte register's write data.
// ----------------------------------------------------------------------------
interface efb_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] flag_byte;

   modport source (output valid, output flag_byte, input ready);
   modport sink   (input valid, input flag_byte, output ready);
endinterface

// ----- design/efb_front.sv -----
// ----------------------------------------------------------------------------
// efb_front: payload classifier
// Accept payload bytes, track frame state, run the CRC and push entries.
// ----------------------------------------------------------------------------
module efb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             in_data,
   input  logic                   in_last,
   output logic                   in_ready,
   input  logic                   q_full,
   output logic                   q_push,
   output efb_pkg::efb_entry_type q_entry
);

   logic [31:0] crc_ff, crc_in;
   logic        open_ff, open_in;
   logic [31:0] crc_next;

   assign in_ready = !q_full;
   assign q_push   = in_valid && !q_full;
   assign crc_next = efb_pkg::crc_update(crc_ff, in_data);

   always_comb begin
      q_entry.data_byte  = in_data;
      q_entry.last_byte  = in_last;
      q_entry.open_frame = !open_ff;
      q_entry.crc_out    = crc_next ^ efb_pkg::CRC_INIT;
   end

   always_comb begin
      crc_in  = crc_ff;
      open_in = open_ff;
      if (q_push) begin
         crc_in  = in_last ? efb_pkg::CRC_INIT : crc_next;
         open_in = !in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= efb_pkg::CRC_INIT;
         open_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         open_ff <= open_in;
      end
   end

endmodule

// ----- design/efb_queue.sv -----
// ----------------------------------------------------------------------------
// efb_queue: entry queue
// Small register FIFO between the classifier and the serializer.
// ----------------------------------------------------------------------------
module efb_queue #(
   parameter int DEPTH = efb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  efb_pkg::efb_entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   empty,
   output efb_pkg::efb_entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   efb_pkg::efb_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/efb_back.sv -----
// ----------------------------------------------------------------------------
// efb_back: line serializer
// Walk one entry into line bytes: flag when opening, escaped data, escaped CRC and flag when last.
// ----------------------------------------------------------------------------
module efb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             flag_byte,
   input  logic                   q_empty,
   input  efb_pkg::efb_entry_type q_head,
   output logic                   q_pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_byte,
   output logic                   out_run_last,
   output logic                   out_frame_end
);

   efb_pkg::efb_phase_type phase_ff, phase_in, phase_eff;
   logic [1:0] idx_ff, idx_in;
   logic       esc_ff, esc_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       run_last_ff, frame_end_ff;

   logic       load;
   logic [7:0] src_byte;
   logic       src_flag, src_esc;
   logic [7:0] cur_byte;
   logic       unit_done, entry_done, cur_end;

   assign load = !q_empty && (!valid_ff || out_ready);

   // Skip the opening flag when the frame is already open.
   assign phase_eff = (phase_ff == efb_pkg::PH_OPEN && !q_head.open_frame)
                      ? efb_pkg::PH_DATA : phase_ff;

   assign src_byte = (phase_eff == efb_pkg::PH_CRC) ? q_head.crc_out[idx_ff*8 +: 8]
                                                     : q_head.data_byte;
   assign src_flag = (src_byte == flag_byte);
   assign src_esc  = (src_byte == efb_pkg::ESC_BYTE);

   // Byte selection for the current phase.
   always_comb begin
      cur_byte  = flag_byte;
      unit_done = 1'b1;
      cur_end   = 1'b0;
      entry_done = 1'b0;
      case (phase_eff)
         efb_pkg::PH_OPEN: begin
            cur_byte  = flag_byte;
            unit_done = 1'b0;
         end
         efb_pkg::PH_DATA, efb_pkg::PH_CRC: begin
            if (esc_ff) begin
               cur_byte = src_flag ? efb_pkg::ESC_FLAG_CODE : efb_pkg::ESC_SELF_CODE;
            end else if (src_flag || src_esc) begin
               cur_byte  = efb_pkg::ESC_BYTE;
               unit_done = 1'b0;
            end else begin
               cur_byte = src_byte;
            end
            entry_done = (phase_eff == efb_pkg::PH_DATA) && unit_done && !q_head.last_byte;
         end
         efb_pkg::PH_CLOSE: begin
            cur_byte   = flag_byte;
            cur_end    = 1'b1;
            entry_done = 1'b1;
         end
         default: begin
            cur_byte = flag_byte;
         end
      endcase
   end

   // Phase sequencing.
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      esc_in   = esc_ff;
      if (load) begin
         case (phase_eff)
            efb_pkg::PH_OPEN: begin
               phase_in = efb_pkg::PH_DATA;
            end
            efb_pkg::PH_DATA: begin
               esc_in = !unit_done;
               if (unit_done) begin
                  phase_in = q_head.last_byte ? efb_pkg::PH_CRC : efb_pkg::PH_OPEN;
                  idx_in   = 2'd0;
               end
            end
            efb_pkg::PH_CRC: begin
               esc_in = !unit_done;
               if (unit_done) begin
                  if (idx_ff == 2'd3) begin
                     phase_in = efb_pkg::PH_CLOSE;
                  end
                  idx_in = idx_ff + 2'd1;
               end
            end
            efb_pkg::PH_CLOSE: begin
               phase_in = efb_pkg::PH_OPEN;
            end
            default: begin
               phase_in = efb_pkg::PH_OPEN;
            end
         endcase
      end
   end

   assign q_pop    = load && entry_done;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= efb_pkg::PH_OPEN;
         idx_ff   <= 2'd0;
         esc_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         esc_ff   <= esc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff      <= cur_byte;
         run_last_ff  <= entry_done;
         frame_end_ff <= cur_end;
      end
   end

   assign out_valid     = valid_ff;
   assign out_byte      = byte_ff;
   assign out_run_last  = run_last_ff;
   assign out_frame_end = frame_end_ff;

endmodule

// ----- design/escaped_frame_builder_crc32.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_builder_crc32: byte-stuffing framer with CRC-32
// Frame payload bytes between flag bytes, escape flag and escape bytes,
// append the escaped reflected CRC-32 before the closing flag.
//
//   channel  | dir | beat carries                         | accept
//   ---------+-----+--------------------------------------+-------------------
//   req_bus  | in  | data_byte, last_byte                 | valid && ready
//   rsp_bus  | out | out_byte, run_last, frame_end        | valid && ready
//   csr_bus  | in  | flag_byte (delimiter register)       | valid (ready = 1)
//
// One line byte leaves per cycle from the output register while rsp_bus is
// ready, so the serializer sets the rate: a payload byte gives one line byte,
// two when escaped, plus the opening flag at a frame's start; a last byte
// adds 4 to 8 CRC bytes and 1 closing flag. The classifier takes a beat
// every cycle while the entry queue has room. Synchronous reset clears frame
// state, CRC, queue and the output valid; the flag register resets to 0x7e.
// A stalled rsp_bus holds its beat while the queue keeps filling.
// ----------------------------------------------------------------------------
module escaped_frame_builder_crc32 #(
   parameter int QUEUE_DEPTH = efb_pkg::QUEUE_DEPTH_DEF
) (
   input logic   clock,
   input logic   reset,
   efb_req_if.sink   req_bus,
   efb_rsp_if.source rsp_bus,
   efb_csr_if.sink   csr_bus
);

   logic [7:0]             flag_ff;
   logic                   q_push, q_pop, q_full, q_empty;
   efb_pkg::efb_entry_type q_entry, q_head;

   // Register writes land at once; hold the flag between writes.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= efb_pkg::FLAG_RESET;
      end else if (csr_bus.valid) begin
         flag_ff <= csr_bus.flag_byte;
      end
   end

   // Front: accept payload beats, advance CRC and frame state.
   efb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_data  (req_bus.data_byte),
      .in_last  (req_bus.last_byte),
      .in_ready (req_bus.ready),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // Decouple the two halves so each can stall on its own.
   efb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   // Back: serialize each entry into line beats.
   efb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .flag_byte     (flag_ff),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .out_valid     (rsp_bus.valid),
      .out_ready     (rsp_bus.ready),
      .out_byte      (rsp_bus.out_byte),
      .out_run_last  (rsp_bus.run_last),
      .out_frame_end (rsp_bus.frame_end)
   );

endmodule

// ----- design/efb_checker.sv -----
// ----------------------------------------------------------------------------
// efb_checker: port-level checks
// Watch the line channel of the framer over time.
// ----------------------------------------------------------------------------
module efb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_frame_end
);

   // Closing flag always ends the run of its beat.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("closing flag without run_last");

   // An escape byte is never the last beat unless it is the closing flag.
   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last && (rsp_out_byte == efb_pkg::ESC_BYTE) |-> rsp_frame_end)
      else $error("escape byte ends a run");

   // Out of reset, no beat is offered.
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("line beat right after reset");

   // A stalled beat holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_frame_end))
      else $error("stalled line beat changed");

endmodule

bind escaped_frame_builder_crc32 efb_checker u_efb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_out_byte  (rsp_bus.out_byte),
   .rsp_run_last  (rsp_bus.run_last),
   .rsp_frame_end (rsp_bus.frame_end)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for escaped_frame_builder_crc32
// Feeds payload bytes into the framer under random stalls on both sides,
// predicts the stuffed line bytes and the appended CRC-32 from a private
// copy of the frame state, and compares every line beat field by field.
// ----------------------------------------------------------------------------

// One expected line byte with its end marks.
typedef struct packed {
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_end;
} line_beat_type;

// Shadow of the framer: flag register, running CRC and frame state, plus
// the line bytes still owed by the block.
class frame_line_model;
   logic [7:0]    flag;
   logic [31:0]   crc;
   bit            in_frame;
   line_beat_type line_q[$];
   int unsigned   errors;
   logic [7:0]    step_byte[12];
   bit            step_end[12];
   int            step_cnt;

   function new();
      flag     = efb_pkg::FLAG_RESET;
      crc      = efb_pkg::CRC_INIT;
      in_frame = 1'b0;
      errors   = 0;
   endfunction

   function void add_byte(logic [7:0] b, bit fe);
      step_byte[step_cnt] = b;
      step_end[step_cnt]  = fe;
      step_cnt++;
   endfunction

   // Flag test wins over the escape test, so a 0x7d flag gives 0x7d 0x02.
   function void add_stuffed(logic [7:0] b);
      if (b == flag) begin
         add_byte(efb_pkg::ESC_BYTE, 1'b0);
         add_byte(efb_pkg::ESC_FLAG_CODE, 1'b0);
      end else if (b == efb_pkg::ESC_BYTE) begin
         add_byte(efb_pkg::ESC_BYTE, 1'b0);
         add_byte(efb_pkg::ESC_SELF_CODE, 1'b0);
      end else begin
         add_byte(b, 1'b0);
      end
   endfunction

   function void take_payload(logic [7:0] d, logic l);
      logic [31:0]   fcs;
      line_beat_type beat;
      step_cnt = 0;
      if (!in_frame) begin
         add_byte(flag, 1'b0);
         in_frame = 1'b1;
      end
      add_stuffed(d);
      crc = crc ^ {24'd0, d};
      for (int k = 0; k < 8; k++) begin
         crc = (crc >> 1) ^ ({32{crc[0]}} & efb_pkg::CRC_POLY);
      end
      if (l) begin
         fcs = crc ^ efb_pkg::CRC_INIT;
         for (int k = 0; k < 4; k++) begin
            add_stuffed(fcs[8*k +: 8]);
         end
         add_byte(flag, 1'b1);
         crc      = efb_pkg::CRC_INIT;
         in_frame = 1'b0;
      end
      for (int i = 0; i < step_cnt; i++) begin
         beat.out_byte  = step_byte[i];
         beat.run_last  = (i == step_cnt - 1);
         beat.frame_end = step_end[i];
         line_q.insert(line_q.size(), beat);
      end
   endfunction

   function void check_line(logic [7:0] b, logic rl, logic fe);
      line_beat_type want;
      if (line_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected line beat byte=%h run_last=%b frame_end=%b",
                  $time, b, rl, fe);
         return;
      end
      want = line_q.pop_front();
      if (want.out_byte !== b) begin
         errors++;
         $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, b);
      end
      if (want.run_last !== rl) begin
         errors++;
         $display("%0t: run_last expected %b actual %b", $time, want.run_last, rl);
      end
      if (want.frame_end !== fe) begin
         errors++;
         $display("%0t: frame_end expected %b actual %b", $time, want.frame_end, fe);
      end
   endfunction

   function int pending();
      return line_q.size();
   endfunction
endclass

module testbench;

   logic clock;
   logic reset;

   efb_req_if req_bus();
   efb_rsp_if rsp_bus();
   efb_csr_if csr_bus();

   frame_line_model model;

   // Percent of cycles in which the payload sender holds off and the line
   // receiver stalls; the main sequence steps these through three settings.
   int unsigned src_idle_pct;
   int unsigned snk_idle_pct;

   escaped_frame_builder_crc32 uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // 10 ns clock, low first so the first rising edge falls at 5 ns.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stall the line side at random, one decision per cycle.
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   // Check every line beat taken at this edge against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         model.check_line(rsp_bus.out_byte, rsp_bus.run_last, rsp_bus.frame_end);
   end

   // Present one payload beat and wait for it to be taken. Valid stays high
   // on return so that back-to-back beats never lower and raise it in the
   // same step; drop it only while idling.
   task automatic send_payload(input logic [7:0] d, input logic l);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= d;
      req_bus.last_byte <= l;
      do @(posedge clock); while (!req_bus.ready);
      model.take_payload(d, l);
   endtask

   // Hold valid low and wait until every owed line byte has come out.
   task automatic drain_lines();
      req_bus.valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
   endtask

   // Write the delimiter register; only called with the block drained.
   task automatic write_flag(input logic [7:0] v);
      csr_bus.valid     <= 1'b1;
      csr_bus.flag_byte <= v;
      do @(posedge clock); while (!csr_bus.ready);
      model.flag = v;
      csr_bus.valid <= 1'b0;
   endtask

   // Bias payload toward the bytes that need stuffing and the extremes.
   function automatic logic [7:0] pick_payload();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10)      return model.flag;
      else if (r < 20) return efb_pkg::ESC_BYTE;
      else if (r < 25) return 8'h00;
      else if (r < 30) return 8'hff;
      else             return 8'($urandom_range(255));
   endfunction

   // Random frames, on average six bytes long.
   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_payload(pick_payload(), ($urandom_range(5) == 0));
      end
   endtask

   initial begin
      model = new();
      src_idle_pct = 26;
      snk_idle_pct = 66;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.flag_byte <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single-byte frames at both data extremes, default flag.
      send_payload(8'h00, 1'b1);
      send_payload(8'hff, 1'b1);
      // Flag and escape bytes inside a longer frame.
      send_payload(efb_pkg::FLAG_RESET, 1'b0);
      send_payload(efb_pkg::ESC_BYTE, 1'b0);
      send_payload(8'h00, 1'b0);
      send_payload(8'hff, 1'b1);
      drain_lines();

      // Flag equal to the escape byte: 0x7d must come out as 0x7d 0x02.
      write_flag(efb_pkg::ESC_BYTE);
      send_payload(efb_pkg::ESC_BYTE, 1'b0);
      send_payload(efb_pkg::FLAG_RESET, 1'b0);
      send_payload(8'h01, 1'b1);
      // Leave a frame open across the next register write.
      send_payload(8'h12, 1'b0);
      drain_lines();

      // New flag applies at once, to stuffing and to the closing flag.
      write_flag(8'h00);
      send_payload(8'h00, 1'b0);
      send_payload(efb_pkg::ESC_BYTE, 1'b0);
      send_payload(efb_pkg::FLAG_RESET, 1'b1);
      drain_lines();

      write_flag(8'hff);
      send_payload(8'hff, 1'b1);
      send_payload(8'h55, 1'b0);
      send_payload(8'haa, 1'b1);
      drain_lines();

      // Random phases: sender light and receiver heavy idling, then the
      // reverse, then none; two flag settings per idling setting.
      write_flag(efb_pkg::FLAG_RESET);
      send_random(27);
      drain_lines();
      write_flag(8'h00);
      send_random(27);
      drain_lines();

      src_idle_pct = 66;
      snk_idle_pct = 26;
      write_flag(8'hff);
      send_random(27);
      drain_lines();
      write_flag(efb_pkg::ESC_BYTE);
      send_random(27);
      drain_lines();

      src_idle_pct = 0;
      snk_idle_pct = 0;
      write_flag(8'($urandom_range(255)));
      send_random(27);
      drain_lines();
      write_flag(8'($urandom_range(255)));
      send_random(27);
      drain_lines();

      // Allow time for any stray beat after the last expected one.
      repeat (30) @(posedge clock);
      if (model.errors == 0 && model.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
